### hw/rtl/pgig_pkg.sv
// Shared types, widths and segment tables of the periodic ghost index generator.
package pgig_pkg;

	localparam int LIVE_W    = 9;
	localparam int GHOST_W   = 4;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CW        = 10;
	localparam int IDX_W     = 25;
	localparam int SEG_W     = 4;
	localparam int MEM_W     = 3;
	localparam int GRP_W     = 4;
	localparam int NUM_AXES  = 3;

	localparam int DEF_MAX_LIVE  = 256;
	localparam int DEF_MAX_GHOST = 8;

	localparam logic [LIVE_W-1:0]  RST_LIVE  = LIVE_W'(16);
	localparam logic [GHOST_W-1:0] RST_GHOST = GHOST_W'(1);

	localparam int NUM_SEG = 10;
	localparam logic [SEG_W-1:0] FIRST_HIGH_SEG   = SEG_W'(3);
	localparam logic [SEG_W-1:0] FIRST_CORNER_SEG = SEG_W'(6);
	localparam logic [SEG_W-1:0] LAST_SEG         = SEG_W'(NUM_SEG - 1);

	// bit a set: axis a walks ghost offsets in that segment
	localparam logic [NUM_AXES-1:0] SEG_AXES [NUM_SEG] = '{
		3'd1, 3'd2, 3'd4, 3'd1, 3'd2, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3
	};
	localparam logic [GRP_W-1:0] SEG_GROUP [NUM_SEG] = '{
		4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd8, 4'd4, 4'd4, 4'd4
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIVE_X      = 3'd0,
		REG_LIVE_Y      = 3'd1,
		REG_LIVE_Z      = 3'd2,
		REG_GHOST_WIDTH = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][LIVE_W-1:0] n;
		logic [GHOST_W-1:0]              g;
	} cfg_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][CW-1:0] c;
		logic [NUM_AXES-1:0]         ghost;
		logic [NUM_AXES-1:0]         high;
		logic                        last;
	} pos_t;

	typedef struct packed {
		logic restart;
		logic advance;
	} walk_cmd_t;

	typedef struct packed {
		logic capture;
		logic rem_step;
		logic mul1;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_sts_t;

endpackage

### hw/rtl/periodic_ghost_index_generator.sv
// Top level: configuration registers, size clamping and block wiring.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | restart
//  output   | out_valid / out_ready| ghost_index, source_index, last_pair
//  config   | cfg_we               | cfg_index, cfg_data
//
// One pair per input transaction; a new transaction is not accepted until the
// pair of the last one has been loaded into the output register.
// The work is done by the 4-step remainder unit (one offset bit per cycle,
// three axis lanes in parallel) and the two index multiply stages.
// Reset: sizes 16 x 16 x 16, ghost width 1, sequence at the first pair.
// A held output stalls the block: the finished pair waits in the last multiply
// stage until the output register frees, and in_ready stays low until then.
module periodic_ghost_index_generator #(
	parameter int MAX_LIVE  = pgig_pkg::DEF_MAX_LIVE,
	parameter int MAX_GHOST = pgig_pkg::DEF_MAX_GHOST
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               restart,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pgig_pkg::IDX_W-1:0]         ghost_index,
	output logic [pgig_pkg::IDX_W-1:0]         source_index,
	output logic                               last_pair,
	input  logic                               cfg_we,
	input  logic [pgig_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pgig_pkg::CFG_W-1:0]         cfg_data
);
	import pgig_pkg::*;

	logic [NUM_AXES-1:0][LIVE_W-1:0] live_q;
	logic [GHOST_W-1:0]              ghost_width_q;
	logic                            cfg_restart;
	logic                            cfg_restart_q;
	cfg_t                            cfg;
	pos_t                            pos;
	walk_cmd_t                       walk_cmd;
	dp_cmd_t                         dp_cmd;
	dp_sts_t                         dp_sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q        <= {NUM_AXES{RST_LIVE}};
			ghost_width_q <= RST_GHOST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIVE_X:      live_q[0]     <= cfg_data[LIVE_W-1:0];
				REG_LIVE_Y:      live_q[1]     <= cfg_data[LIVE_W-1:0];
				REG_LIVE_Z:      live_q[2]     <= cfg_data[LIVE_W-1:0];
				REG_GHOST_WIDTH: ghost_width_q <= cfg_data[GHOST_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_restart = cfg_we && (cfg_index == REG_LIVE_X || cfg_index == REG_LIVE_Y
		|| cfg_index == REG_LIVE_Z || cfg_index == REG_GHOST_WIDTH);

	// restart in the cycle after the write so the walker starts from the new sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_restart_q <= 1'b0;
		else
			cfg_restart_q <= cfg_restart;
	end

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			priority if (live_q[a] == '0)
				cfg.n[a] = LIVE_W'(1);
			else if (32'(live_q[a]) > 32'(MAX_LIVE))
				cfg.n[a] = LIVE_W'(MAX_LIVE);
			else
				cfg.n[a] = live_q[a];
		end
		priority if (ghost_width_q == '0)
			cfg.g = GHOST_W'(1);
		else if (32'(ghost_width_q) > 32'(MAX_GHOST))
			cfg.g = GHOST_W'(MAX_GHOST);
		else
			cfg.g = ghost_width_q;
	end

	pgig_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.restart     (restart),
		.cfg_restart (cfg_restart_q),
		.dp_sts      (dp_sts),
		.walk_cmd    (walk_cmd),
		.dp_cmd      (dp_cmd)
	);

	pgig_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (walk_cmd),
		.pos    (pos)
	);

	pgig_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pos          (pos),
		.cmd          (dp_cmd),
		.sts          (dp_sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ghost_index  (ghost_index),
		.source_index (source_index),
		.last_pair    (last_pair)
	);

endmodule

### hw/rtl/pgig_walk.sv
// Position walker: segment, ghost offsets and group member of the next pair.
module pgig_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  pgig_pkg::cfg_t      cfg,
	input  pgig_pkg::walk_cmd_t cmd,
	output pgig_pkg::pos_t      pos
);
	import pgig_pkg::*;

	logic [SEG_W-1:0]            seg_q;
	logic [NUM_AXES-1:0][CW-1:0] cnt_q;
	logic [MEM_W-1:0]            mem_q;

	logic [NUM_AXES-1:0]         axes;
	logic [NUM_AXES-1:0]         axes_nxt;
	logic [GRP_W-1:0]            grp;
	logic [SEG_W-1:0]            seg_nxt;
	logic [NUM_AXES-1:0][CW-1:0] lo;
	logic [NUM_AXES-1:0][CW-1:0] lo_nxt;
	logic [NUM_AXES-1:0][CW-1:0] lo_first;
	logic [NUM_AXES-1:0]         wrap;
	logic                        grp_done;
	logic [MEM_W-1:0]            sides;
	logic [1:0]                  bit_idx [NUM_AXES];

	always_comb begin
		axes     = SEG_AXES[seg_q];
		grp      = SEG_GROUP[seg_q];
		seg_nxt  = (seg_q == LAST_SEG) ? '0 : seg_q + SEG_W'(1);
		axes_nxt = SEG_AXES[seg_nxt];
		grp_done = ({1'b0, mem_q} + GRP_W'(1)) >= grp;
		for (int a = 0; a < NUM_AXES; a++) begin
			lo[a]       = axes[a] ? '0 : CW'(cfg.g);
			lo_nxt[a]   = axes_nxt[a] ? '0 : CW'(cfg.g);
			lo_first[a] = SEG_AXES[0][a] ? '0 : CW'(cfg.g);
			wrap[a]     = ({1'b0, cnt_q[a]} + (CW+1)'(1)) >=
				(axes[a] ? (CW+1)'(cfg.g) : (CW+1)'(cfg.n[a]) + (CW+1)'(cfg.g));
		end
		priority if (seg_q < FIRST_HIGH_SEG)
			sides = '0;
		else if (seg_q < FIRST_CORNER_SEG)
			sides = MEM_W'(1);
		else
			sides = mem_q;
		bit_idx[0] = 2'd0;
		bit_idx[1] = {1'b0, axes[0]};
		bit_idx[2] = 2'({1'b0, axes[0]} + {1'b0, axes[1]});
		for (int a = 0; a < NUM_AXES; a++) begin
			pos.high[a] = sides[bit_idx[a]];
		end
		pos.c     = cnt_q;
		pos.ghost = axes;
		pos.last  = (seg_q == LAST_SEG) && grp_done && (&wrap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q    <= '0;
			cnt_q[0] <= '0;
			cnt_q[1] <= CW'(RST_GHOST);
			cnt_q[2] <= CW'(RST_GHOST);
			mem_q    <= '0;
		end else if (cmd.restart) begin
			seg_q <= '0;
			cnt_q <= lo_first;
			mem_q <= '0;
		end else if (cmd.advance) begin
			if (!grp_done) begin
				mem_q <= mem_q + MEM_W'(1);
			end else begin
				mem_q <= '0;
				if (!wrap[0]) begin
					cnt_q[0] <= cnt_q[0] + CW'(1);
				end else if (!wrap[1]) begin
					cnt_q[0] <= lo[0];
					cnt_q[1] <= cnt_q[1] + CW'(1);
				end else if (!wrap[2]) begin
					cnt_q[0] <= lo[0];
					cnt_q[1] <= lo[1];
					cnt_q[2] <= cnt_q[2] + CW'(1);
				end else begin
					seg_q <= seg_nxt;
					cnt_q <= lo_nxt;
				end
			end
		end
	end

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		seg_q < SEG_W'(NUM_SEG))
		else $error("segment out of range");

	a_mem_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, mem_q} < SEG_GROUP[seg_q])
		else $error("group member beyond group size");

endmodule

### hw/rtl/pgig_dp.sv
// Datapath: per-axis remainder lanes, index multiply stages and output register.
module pgig_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pgig_pkg::cfg_t         cfg,
	input  pgig_pkg::pos_t         pos,
	input  pgig_pkg::dp_cmd_t      cmd,
	output pgig_pkg::dp_sts_t      sts,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [pgig_pkg::IDX_W-1:0] ghost_index,
	output logic [pgig_pkg::IDX_W-1:0] source_index,
	output logic                   last_pair
);
	import pgig_pkg::*;

	localparam int M1_W = 2 * CW + 1;
	localparam int M2_W = 3 * CW + 2;

	logic [NUM_AXES-1:0][CW-1:0]      c_q;
	logic [NUM_AXES-1:0]              ghost_q;
	logic [NUM_AXES-1:0]              high_q;
	logic                             last_q;
	logic [NUM_AXES-1:0][GHOST_W-1:0] num_q;
	logic [NUM_AXES-1:0][GHOST_W-1:0] rem_q;
	logic [M1_W-1:0]                  tg_s1;
	logic [M1_W-1:0]                  ts_s1;
	logic                             out_valid_q;
	logic [IDX_W-1:0]                 gidx_q;
	logic [IDX_W-1:0]                 sidx_q;
	logic                             last_pair_q;

	logic [NUM_AXES-1:0][CW-1:0]      gc;
	logic [NUM_AXES-1:0][CW-1:0]      sc;
	logic [NUM_AXES-1:0][GHOST_W:0]   trial;
	logic [NUM_AXES-1:0][GHOST_W-1:0] num_init;
	logic [CW-1:0]                    px;
	logic [CW-1:0]                    py;
	logic [2*CW-1:0]                  mg1;
	logic [2*CW-1:0]                  ms1;
	logic [M2_W-1:0]                  sum_g;
	logic [M2_W-1:0]                  sum_s;

	always_comb begin
		px = CW'(cfg.n[0]) + (CW'(cfg.g) << 1);
		py = CW'(cfg.n[1]) + (CW'(cfg.g) << 1);
		for (int a = 0; a < NUM_AXES; a++) begin
			num_init[a] = pos.high[a] ? pos.c[a][GHOST_W-1:0]
				: cfg.g - GHOST_W'(1) - pos.c[a][GHOST_W-1:0];
			trial[a] = {rem_q[a], num_q[a][GHOST_W-1]};
			if (!ghost_q[a]) begin
				gc[a] = c_q[a];
				sc[a] = c_q[a];
			end else if (high_q[a]) begin
				gc[a] = CW'(cfg.n[a]) + CW'(cfg.g) + c_q[a];
				sc[a] = CW'(cfg.g) + CW'(rem_q[a]);
			end else begin
				gc[a] = c_q[a];
				sc[a] = CW'(cfg.n[a]) + CW'(cfg.g) - CW'(1) - CW'(rem_q[a]);
			end
		end
		mg1   = py * gc[2];
		ms1   = py * sc[2];
		sum_g = M2_W'(px) * M2_W'(tg_s1) + M2_W'(gc[0]);
		sum_s = M2_W'(px) * M2_W'(ts_s1) + M2_W'(sc[0]);
	end

	// remainder lanes: one numerator bit per step, all axes in parallel
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			c_q     <= pos.c;
			ghost_q <= pos.ghost;
			high_q  <= pos.high;
			last_q  <= pos.last;
			num_q   <= num_init;
			rem_q   <= '0;
		end else if (cmd.rem_step) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				num_q[a] <= num_q[a] << 1;
				if (LIVE_W'(trial[a]) >= cfg.n[a])
					rem_q[a] <= GHOST_W'(LIVE_W'(trial[a]) - cfg.n[a]);
				else
					rem_q[a] <= GHOST_W'(trial[a]);
			end
		end
		if (cmd.mul1) begin
			tg_s1 <= {1'b0, mg1} + M1_W'(gc[1]);
			ts_s1 <= {1'b0, ms1} + M1_W'(sc[1]);
		end
		if (cmd.load) begin
			gidx_q      <= sum_g[IDX_W-1:0];
			sidx_q      <= sum_s[IDX_W-1:0];
			last_pair_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign sts.slot_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign ghost_index   = gidx_q;
	assign source_index  = sidx_q;
	assign last_pair     = last_pair_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before transaction");

	a_rise_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load))
		else $error("output valid without load");

endmodule

### hw/rtl/pgig_ctrl.sv
// Controller: sequences capture, remainder steps, multiply stages and load.
module pgig_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	input  logic                 cfg_restart,
	input  pgig_pkg::dp_sts_t    dp_sts,
	output pgig_pkg::walk_cmd_t  walk_cmd,
	output pgig_pkg::dp_cmd_t    dp_cmd
);
	import pgig_pkg::*;

	localparam int STEP_W = $clog2(GHOST_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_REM,
		ST_MUL1,
		ST_MUL2
	} state_t;

	state_t            state_q;
	logic              ready_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign accept   = in_valid && ready_q;
	assign in_ready = ready_q;

	always_comb begin
		walk_cmd.restart = (accept && restart) || cfg_restart;
		walk_cmd.advance = (state_q == ST_PREP);
		dp_cmd.capture   = (state_q == ST_PREP);
		dp_cmd.rem_step  = (state_q == ST_REM);
		dp_cmd.mul1      = (state_q == ST_MUL1);
		dp_cmd.load      = (state_q == ST_MUL2) && dp_sts.slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PREP;
						ready_q <= 1'b0;
					end
				end
				ST_PREP: begin
					state_q <= ST_REM;
					step_q  <= '0;
				end
				ST_REM: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(GHOST_W - 1))
						state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					if (dp_sts.slot_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_PREP) && !ready_q)
		else $error("transaction accepted without starting work");

endmodule

### tb/periodic_ghost_index_generator_tb.sv
`timescale 1ns / 1ps
// Testbench for the periodic ghost index generator: directed table, then random phases.
module periodic_ghost_index_generator_tb;
	import pgig_pkg::*;

	localparam int NSEG          = 10;
	localparam int MAX_LIVE_EFF  = DEF_MAX_LIVE;
	localparam int MAX_GHOST_EFF = DEF_MAX_GHOST;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 1050;

	localparam logic [2:0] WALK_AXES [NSEG] = '{
		3'd1, 3'd2, 3'd4, 3'd1, 3'd2, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3
	};
	localparam int GROUP_MEMBERS [NSEG] = '{1, 1, 1, 1, 1, 1, 8, 4, 4, 4};

	typedef struct packed {
		logic [IDX_W-1:0] ghost;
		logic [IDX_W-1:0] source;
		logic             last;
	} ghost_pair_t;

	typedef enum logic {ROW_SEND, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     data;
		logic                 rs;
		logic                 known;
		ghost_pair_t          want;
	} dir_row_t;

	localparam int N_DIRECTED = 44;
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b1, '{25'd342, 25'd358, 1'b0}},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b1, '{25'd360, 25'd376, 1'b0}},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b1, 1'b1, '{25'd342, 25'd358, 1'b0}},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_X,      9'd1,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Y,      9'd1,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Z,      9'd1,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_GHOST_WIDTH, 9'd1,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b1, '{25'd12, 25'd13, 1'b0}},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		// zero sizes act as one
		'{ROW_WRITE, REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Y,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Z,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_GHOST_WIDTH, 9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b1, '{25'd12, 25'd13, 1'b0}},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		// oversize values clamp to the maxima
		'{ROW_WRITE, REG_LIVE_X,      9'd511, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Y,      9'd511, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Z,      9'd511, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_GHOST_WIDTH, 9'd15,  1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b1, '{25'd594048, 25'd594304, 1'b0}},
		// unknown register: ignored, no restart
		'{ROW_WRITE, CFG_IDX_W'(REG_GHOST_WIDTH + 2), 9'd3, 1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b1, '{25'd594049, 25'd594305, 1'b0}},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b1, 1'b1, '{25'd594048, 25'd594304, 1'b0}},
		// ghost width above live size, upper data bits set
		'{ROW_WRITE, REG_LIVE_X,      9'd2,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Y,      9'd3,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Z,      9'd1,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_GHOST_WIDTH, 9'h1F5, 1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b1, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_X,      9'd256, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Y,      9'd1,   1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_LIVE_Z,      9'd256, 1'b0, 1'b0, '0},
		'{ROW_WRITE, REG_GHOST_WIDTH, 9'd8,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0},
		'{ROW_SEND,  REG_LIVE_X,      9'd0,   1'b0, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 restart;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [IDX_W-1:0]     ghost_index;
	logic [IDX_W-1:0]     source_index;
	logic                 last_pair;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	periodic_ghost_index_generator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ghost_index  (ghost_index),
		.source_index (source_index),
		.last_pair    (last_pair),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [LIVE_W-1:0]  live_reg [NUM_AXES];
	logic [GHOST_W-1:0] ghost_reg;
	int                 seg_now;
	int                 walk [NUM_AXES];
	int                 member;

	ghost_pair_t pending_pairs [$];
	ghost_pair_t want_pair;
	int          mismatch_count = 0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	int          rx_stall_left = 0;

	function automatic int live_cells(input int axis);
		int v;
		v = live_reg[axis];
		if (v == 0) return 1;
		if (v > MAX_LIVE_EFF) return MAX_LIVE_EFF;
		return v;
	endfunction

	function automatic int ghost_cells();
		int v;
		v = ghost_reg;
		if (v == 0) return 1;
		if (v > MAX_GHOST_EFF) return MAX_GHOST_EFF;
		return v;
	endfunction

	function automatic int walk_lo(input int s, input int a);
		return WALK_AXES[s][a] ? 0 : ghost_cells();
	endfunction

	function automatic int walk_hi(input int s, input int a);
		return WALK_AXES[s][a] ? ghost_cells() : live_cells(a) + ghost_cells();
	endfunction

	function automatic void enter_segment();
		for (int a = 0; a < NUM_AXES; a++)
			walk[a] = walk_lo(seg_now, a);
		member = 0;
	endfunction

	function automatic void rewind_map();
		seg_now = 0;
		enter_segment();
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_LIVE_X:      live_reg[0] = data;
			REG_LIVE_Y:      live_reg[1] = data;
			REG_LIVE_Z:      live_reg[2] = data;
			REG_GHOST_WIDTH: ghost_reg = data[GHOST_W-1:0];
			default:         return;
		endcase
		rewind_map();
	endfunction

	function automatic ghost_pair_t next_ghost_pair(input logic rs);
		ghost_pair_t     p;
		int              g;
		int              n;
		int              c;
		int              sides;
		int              bitpos;
		bit              hi_side;
		longint unsigned gc [NUM_AXES];
		longint unsigned sc [NUM_AXES];
		longint unsigned px;
		longint unsigned py;
		g = ghost_cells();
		bitpos = 0;
		if (rs)
			rewind_map();
		sides = (seg_now < 3) ? 0 : (seg_now < 6) ? 1 : member;
		for (int a = 0; a < NUM_AXES; a++) begin
			n = live_cells(a);
			c = walk[a];
			if (WALK_AXES[seg_now][a]) begin
				hi_side = (sides >> bitpos) & 1;
				bitpos++;
				if (hi_side) begin
					gc[a] = n + g + c;
					sc[a] = g + c % n;
				end else begin
					gc[a] = c;
					sc[a] = n + g - 1 - (g - 1 - c) % n;
				end
			end else begin
				gc[a] = c;
				sc[a] = c;
			end
		end
		px = live_cells(0) + 2 * g;
		py = live_cells(1) + 2 * g;
		p.ghost  = IDX_W'(gc[0] + px * (gc[1] + py * gc[2]));
		p.source = IDX_W'(sc[0] + px * (sc[1] + py * sc[2]));
		p.last   = (seg_now == NSEG - 1) && (member + 1 >= GROUP_MEMBERS[seg_now])
			&& (walk[0] + 1 >= walk_hi(seg_now, 0))
			&& (walk[1] + 1 >= walk_hi(seg_now, 1))
			&& (walk[2] + 1 >= walk_hi(seg_now, 2));

		member++;
		if (member >= GROUP_MEMBERS[seg_now]) begin
			member = 0;
			walk[0]++;
			if (walk[0] >= walk_hi(seg_now, 0)) begin
				walk[0] = walk_lo(seg_now, 0);
				walk[1]++;
				if (walk[1] >= walk_hi(seg_now, 1)) begin
					walk[1] = walk_lo(seg_now, 1);
					walk[2]++;
					if (walk[2] >= walk_hi(seg_now, 2)) begin
						seg_now = (seg_now + 1) % NSEG;
						enter_segment();
					end
				end
			end
		end
		return p;
	endfunction

	// mostly none, often short, sometimes long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [CFG_W-1:0] pick_live();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)  return '0;
		if (r < 14) return CFG_W'(256);
		if (r < 18) return CFG_W'($urandom_range(257, 511));
		if (r < 22) return CFG_W'($urandom_range(6, 255));
		return CFG_W'($urandom_range(1, 5));
	endfunction

	function automatic logic [CFG_W-1:0] pick_ghost();
		int                         r;
		logic [GHOST_W-1:0]         g;
		logic [CFG_W-GHOST_W-1:0]   up;
		r = $urandom_range(0, 99);
		if (r < 8)       g = '0;
		else if (r < 14) g = GHOST_W'($urandom_range(9, 15));
		else if (r < 20) g = GHOST_W'($urandom_range(3, 8));
		else             g = GHOST_W'($urandom_range(1, 2));
		// upper data bits are don't-care for this register
		up = $urandom_range(0, 1) ? (CFG_W-GHOST_W)'($urandom) : '0;
		return {up, g};
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		apply_reg(idx, data);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pair_request(input logic rs, input logic known, input ghost_pair_t typed);
		ghost_pair_t p;
		int          gap;
		in_valid <= 1'b1;
		restart  <= rs;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		p = next_ghost_pair(rs);
		pending_pairs.push_back(known ? typed : p);
		gap = tx_idle_en ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		int len;
		if (rx_stall_left > 0) begin
			rx_stall_left <= rx_stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			len = rx_idle_en ? idle_len() : 0;
			if (len > 0) begin
				rx_stall_left <= len - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pairs.size() == 0) begin
				$error("unexpected transaction: ghost_index %0d source_index %0d",
					ghost_index, source_index);
				mismatch_count++;
			end else begin
				want_pair = pending_pairs.pop_front();
				if (ghost_index !== want_pair.ghost) begin
					$error("ghost_index: expected %0d, got %0d", want_pair.ghost, ghost_index);
					mismatch_count++;
				end
				if (source_index !== want_pair.source) begin
					$error("source_index: expected %0d, got %0d",
						want_pair.source, source_index);
					mismatch_count++;
				end
				if (last_pair !== want_pair.last) begin
					$error("last_pair: expected %0b, got %0b", want_pair.last, last_pair);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int sent;
		int phase_len;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		restart   <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_LIVE_X;
		cfg_data  <= '0;
		for (int a = 0; a < NUM_AXES; a++)
			live_reg[a] = RST_LIVE;
		ghost_reg = RST_GHOST;
		rewind_map();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == ROW_WRITE)
				program_reg(DIRECTED[i].reg_idx, DIRECTED[i].data);
			else
				send_pair_request(DIRECTED[i].rs, DIRECTED[i].known, DIRECTED[i].want);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			tx_idle_en = $urandom_range(0, 4) != 0;
			rx_idle_en = $urandom_range(0, 4) != 0;
			program_reg(REG_LIVE_X, pick_live());
			program_reg(REG_LIVE_Y, pick_live());
			program_reg(REG_LIVE_Z, pick_live());
			program_reg(REG_GHOST_WIDTH, pick_ghost());
			if ($urandom_range(0, 3) == 0)
				program_reg(CFG_IDX_W'(REG_GHOST_WIDTH + $urandom_range(1, 4)), CFG_W'($urandom));
			phase_len = $urandom_range(30, 120);
			for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				// hold off until the pipe is empty now and then
				if ($urandom_range(0, 199) == 0)
					settle();
				send_pair_request($urandom_range(0, 99) < 3, 1'b0, '0);
				sent++;
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
